@@ sv/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared constants, command and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int TIME_BITS_DEF = 48;
   localparam int OUT_LIMIT     = 16;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 128;

   localparam logic [1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [1:0] CMD_CANCEL   = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;
   localparam logic [1:0] CMD_SHUTDOWN = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_CLOSED    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   localparam logic [3:0] KIND_MAX = 4'd7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_CHK,
      S_DEC,
      S_MRD,
      S_MWR,
      S_INS,
      S_ERD,
      S_ELD,
      S_RSP
   } state_type;

endpackage

@@ sv/dtq_ram.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/deadline_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue core
// Sorted table of pending deadlines (one per owner) held in a circular RAM.
// ----------------------------------------------------------------------------
// Schedule and cancel search the pending entries, shift entries one slot at a
//   time to open or close a gap, then return one result beat.
// Tick: scan the due entries, then emit one result beat per popped entry.
// Throughput: one request at a time; the single RAM read port paces the work.
// Reset: table empty, arm sequence back to 1, block open, max_entries 16.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
   parameter int CAPACITY  = dtq_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beat
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // owner_id[31:0], deadline_kind[35:32], deadline_time[83:36],
   // cancel_seq[115:84], now_time[163:116], zero pad
   input  logic [dtq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  logic [1:0]                      req_tuser,
   // result beat
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_owner[31:0], out_seq[63:32], out_kind[66:64], out_deadline[114:67],
   // entry_count[119:115], is_closed[120], zero pad
   output logic [dtq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[2:0], fired[3]
   output logic [3:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   // max_entries write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [4:0]                      csr_data
);

   import dtq_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;
   localparam int EW   = 32 + 32 + 3 + TIME_BITS;

   // entry word layout
   localparam int E_OWN = 0;
   localparam int E_SEQ = 32;
   localparam int E_KND = 64;
   localparam int E_DL  = 67;

   state_type state_ff, state_in;

   // table bookkeeping
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [31:0]          seq_ff, seq_in;
   logic                 closed_ff, closed_in;
   logic [4:0]           max_ff;

   // latched request
   logic [1:0]           r_cmd_ff, r_cmd_in;
   logic [31:0]          r_owner_ff, r_owner_in;
   logic [2:0]           r_kind_ff, r_kind_in;
   logic [TIME_BITS-1:0] r_dl_ff, r_dl_in;
   logic [31:0]          r_cseq_ff, r_cseq_in;
   logic [TIME_BITS-1:0] r_now_ff, r_now_in;

   // scan and move counters
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        fidx_ff, fidx_in;
   logic                 found_ff, found_in;
   logic                 smatch_ff, smatch_in;
   logic [CW-1:0]        dst_ff, dst_in;
   logic [CW-1:0]        end_ff, end_in;
   logic                 dirdec_ff, dirdec_in;
   logic [CW-1:0]        ej_ff, ej_in;
   logic                 emit_ff, emit_in;
   logic [31:0]          aseq_ff, aseq_in;

   // result register
   logic                 rv_ff, rv_in;
   logic [2:0]           rst_ff, rst_in;
   logic                 rfired_ff, rfired_in;
   logic [31:0]          rown_ff, rown_in;
   logic [31:0]          rseq_ff, rseq_in;
   logic [2:0]           rknd_ff, rknd_in;
   logic [47:0]          rdl_ff, rdl_in;
   logic [4:0]           rcnt_ff, rcnt_in;
   logic                 rlast_ff, rlast_in;

   // RAM port
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [EW-1:0]        ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [EW-1:0]        ram_rdata;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 req_bad;
   logic [31:0]          q_owner;
   logic [31:0]          q_seq;
   logic [2:0]           q_kind;
   logic [TIME_BITS-1:0] q_dl;
   logic                 q_before;
   logic                 q_due;
   logic [CMPW-1:0]      limit;
   logic [CW-1:0]        idx_nx;
   logic [CW-1:0]        src_idx;
   logic [CW-1:0]        dst_nx;
   logic                 scan_more;
   logic                 tick_more;
   logic                 full;
   logic [CW-1:0]        sched_dst;

   // Map a logical table position onto the circular RAM.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                          input logic [CW-1:0] i);
      logic [AW+1:0] s;
      s = (AW+2)'(hd) + (AW+2)'(i);
      if (s >= (AW+2)'(CAPACITY)) begin
         s = s - (AW+2)'(CAPACITY);
      end
      return s[AW-1:0];
   endfunction

   dtq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_fire  = req_tvalid & req_tready;
   assign rsp_fire  = rv_ff & rsp_tready;
   assign csr_ready = 1'b1;
   assign req_bad   = (req_tdata[31:0] == 32'd0) || (req_tdata[35:32] > KIND_MAX);

   assign q_owner = ram_rdata[E_OWN +: 32];
   assign q_seq   = ram_rdata[E_SEQ +: 32];
   assign q_kind  = ram_rdata[E_KND +: 3];
   assign q_dl    = ram_rdata[E_DL +: TIME_BITS];

   // new entry sorts ahead of the stored one
   assign q_before = (r_dl_ff < q_dl) || ((r_dl_ff == q_dl) && (r_owner_ff < q_owner));
   assign q_due    = (q_dl <= r_now_ff);

   assign limit   = (CMPW'(max_ff) < CMPW'(CAPACITY)) ? CMPW'(max_ff) : CMPW'(CAPACITY);
   assign idx_nx  = idx_ff + CW'(1);
   assign src_idx = dirdec_ff ? (dst_ff - CW'(1)) : (dst_ff + CW'(1));
   assign dst_nx  = src_idx;
   assign scan_more = (idx_nx < cnt_ff);
   assign tick_more = scan_more && (CMPW'(idx_nx) < CMPW'(OUT_LIMIT));
   assign full      = !found_ff && (CMPW'(cnt_ff) >= limit);
   assign sched_dst = found_ff ? fidx_ff : cnt_ff;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_SCHEDULE: begin
                     if (req_bad || closed_ff) begin
                        state_in = S_RSP;
                     end else begin
                        state_in = (cnt_ff == '0) ? S_DEC : S_RD;
                     end
                  end
                  CMD_CANCEL: begin
                     if (closed_ff) begin
                        state_in = S_RSP;
                     end else begin
                        state_in = (cnt_ff == '0) ? S_DEC : S_RD;
                     end
                  end
                  CMD_TICK: begin
                     state_in = (cnt_ff == '0) ? S_DEC : S_RD;
                  end
                  default: begin
                     state_in = S_RSP;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (r_cmd_ff == CMD_TICK) begin
               state_in = (q_due && tick_more) ? S_RD : S_DEC;
            end else begin
               state_in = scan_more ? S_RD : S_DEC;
            end
         end
         S_DEC: begin
            case (r_cmd_ff)
               CMD_SCHEDULE: begin
                  if (full || (seq_ff == 32'd0)) begin
                     state_in = S_RSP;
                  end else begin
                     state_in = (sched_dst != pos_ff) ? S_MRD : S_INS;
                  end
               end
               CMD_CANCEL: begin
                  if (found_ff && smatch_ff && (r_owner_ff != 32'd0) &&
                      (fidx_ff != cnt_ff - CW'(1))) begin
                     state_in = S_MRD;
                  end else begin
                     state_in = S_RSP;
                  end
               end
               default: begin
                  state_in = (idx_ff == '0) ? S_RSP : S_ERD;
               end
            endcase
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            if (dst_nx == end_ff) begin
               state_in = (r_cmd_ff == CMD_SCHEDULE) ? S_INS : S_RSP;
            end else begin
               state_in = S_MRD;
            end
         end
         S_INS: begin
            state_in = S_RSP;
         end
         S_ERD: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_tready) begin
               state_in = (emit_ff && !rlast_ff) ? S_ERD : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath, RAM controls and result loading
   // ------------------------------------------------------------------------
   always_comb begin
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      seq_in     = seq_ff;
      closed_in  = closed_ff;
      r_cmd_in   = r_cmd_ff;
      r_owner_in = r_owner_ff;
      r_kind_in  = r_kind_ff;
      r_dl_in    = r_dl_ff;
      r_cseq_in  = r_cseq_ff;
      r_now_in   = r_now_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      fidx_in    = fidx_ff;
      found_in   = found_ff;
      smatch_in  = smatch_ff;
      dst_in     = dst_ff;
      end_in     = end_ff;
      dirdec_in  = dirdec_ff;
      ej_in      = ej_ff;
      emit_in    = emit_ff;
      aseq_in    = aseq_ff;
      rv_in      = rv_ff;
      rst_in     = rst_ff;
      rfired_in  = rfired_ff;
      rown_in    = rown_ff;
      rseq_in    = rseq_ff;
      rknd_in    = rknd_ff;
      rdl_in     = rdl_ff;
      rcnt_in    = rcnt_ff;
      rlast_in   = rlast_ff;
      ram_we     = 1'b0;
      ram_waddr  = phys(head_ff, dst_ff);
      ram_wdata  = ram_rdata;
      ram_raddr  = phys(head_ff, idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // latch the request and clear the scan state
               r_cmd_in   = req_tuser;
               r_owner_in = req_tdata[31:0];
               r_kind_in  = req_tdata[34:32];
               r_dl_in    = TIME_BITS'(req_tdata[83:36]);
               r_cseq_in  = req_tdata[115:84];
               r_now_in   = TIME_BITS'(req_tdata[163:116]);
               idx_in     = '0;
               pos_in     = '0;
               fidx_in    = '0;
               found_in   = 1'b0;
               smatch_in  = 1'b0;
               emit_in    = 1'b0;
               rfired_in  = 1'b0;
               rown_in    = '0;
               rseq_in    = '0;
               rknd_in    = '0;
               rdl_in     = '0;
               rlast_in   = 1'b1;
               rcnt_in    = 5'(cnt_ff);
               rst_in     = ST_OK;
               case (req_tuser)
                  CMD_SCHEDULE: begin
                     if (req_bad) begin
                        rv_in  = 1'b1;
                        rst_in = ST_INVALID;
                     end else if (closed_ff) begin
                        rv_in  = 1'b1;
                        rst_in = ST_CLOSED;
                     end
                  end
                  CMD_CANCEL: begin
                     if (closed_ff) begin
                        rv_in  = 1'b1;
                        rst_in = ST_CLOSED;
                     end
                  end
                  CMD_TICK: begin
                  end
                  default: begin
                     // shutdown: drop every entry and close for good
                     closed_in = 1'b1;
                     cnt_in    = '0;
                     rcnt_in   = '0;
                     rv_in     = 1'b1;
                  end
               endcase
            end
         end
         S_CHK: begin
            case (r_cmd_ff)
               CMD_SCHEDULE: begin
                  if (!found_ff && (q_owner == r_owner_ff)) begin
                     found_in = 1'b1;
                     fidx_in  = idx_ff;
                  end else if (!q_before) begin
                     pos_in = pos_ff + CW'(1);
                  end
                  idx_in = idx_nx;
               end
               CMD_CANCEL: begin
                  if (!found_ff && (q_owner == r_owner_ff)) begin
                     found_in  = 1'b1;
                     fidx_in   = idx_ff;
                     smatch_in = (q_seq == r_cseq_ff);
                  end
                  idx_in = idx_nx;
               end
               default: begin
                  // idx counts the due prefix
                  if (q_due) begin
                     idx_in = idx_nx;
                  end
               end
            endcase
         end
         S_DEC: begin
            case (r_cmd_ff)
               CMD_SCHEDULE: begin
                  if (full) begin
                     rv_in  = 1'b1;
                     rst_in = ST_FULL;
                  end else if (seq_ff == 32'd0) begin
                     rv_in  = 1'b1;
                     rst_in = ST_EXHAUSTED;
                  end else begin
                     aseq_in   = seq_ff;
                     seq_in    = seq_ff + 32'd1;
                     dst_in    = sched_dst;
                     end_in    = pos_ff;
                     dirdec_in = !found_ff || (pos_ff <= fidx_ff);
                  end
               end
               CMD_CANCEL: begin
                  if (found_ff && smatch_ff && (r_owner_ff != 32'd0)) begin
                     dst_in    = fidx_ff;
                     end_in    = cnt_ff - CW'(1);
                     dirdec_in = 1'b0;
                     if (fidx_ff == cnt_ff - CW'(1)) begin
                        cnt_in  = cnt_ff - CW'(1);
                        rcnt_in = 5'(cnt_ff - CW'(1));
                        rv_in   = 1'b1;
                        rst_in  = ST_OK;
                     end
                  end else begin
                     rv_in  = 1'b1;
                     rst_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  if (idx_ff == '0) begin
                     rv_in  = 1'b1;
                     rst_in = closed_ff ? ST_CLOSED : ST_OK;
                  end else begin
                     emit_in = 1'b1;
                     ej_in   = '0;
                  end
               end
            endcase
         end
         S_MRD: begin
            ram_raddr = phys(head_ff, src_idx);
         end
         S_MWR: begin
            // move one entry by one slot toward the gap
            ram_we    = 1'b1;
            ram_waddr = phys(head_ff, dst_ff);
            ram_wdata = ram_rdata;
            dst_in    = dst_nx;
            if ((dst_nx == end_ff) && (r_cmd_ff == CMD_CANCEL)) begin
               cnt_in  = cnt_ff - CW'(1);
               rcnt_in = 5'(cnt_ff - CW'(1));
               rv_in   = 1'b1;
               rst_in  = ST_OK;
            end
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_ff, pos_ff);
            ram_wdata = {r_dl_ff, r_kind_ff, aseq_ff, r_owner_ff};
            if (!found_ff) begin
               cnt_in  = cnt_ff + CW'(1);
               rcnt_in = 5'(cnt_ff + CW'(1));
            end
            rv_in   = 1'b1;
            rst_in  = ST_OK;
            rown_in = r_owner_ff;
            rseq_in = aseq_ff;
            rknd_in = r_kind_ff;
            rdl_in  = 48'(r_dl_ff);
         end
         S_ERD: begin
            ram_raddr = phys(head_ff, ej_ff);
         end
         S_ELD: begin
            rv_in     = 1'b1;
            rst_in    = ST_OK;
            rfired_in = 1'b1;
            rown_in   = q_owner;
            rseq_in   = q_seq;
            rknd_in   = q_kind;
            rdl_in    = 48'(q_dl);
            rcnt_in   = 5'(cnt_ff - idx_ff);
            rlast_in  = (ej_ff == idx_ff - CW'(1));
         end
         S_RSP: begin
            if (rsp_fire) begin
               rv_in = 1'b0;
               if (emit_ff) begin
                  if (rlast_ff) begin
                     // retire the popped prefix
                     head_in = phys(head_ff, idx_ff);
                     cnt_in  = cnt_ff - idx_ff;
                     emit_in = 1'b0;
                  end else begin
                     ej_in = ej_ff + CW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         cnt_ff    <= '0;
         seq_ff    <= 32'd1;
         closed_ff <= 1'b0;
         max_ff    <= 5'(CAPACITY_DEF);
         rv_ff     <= 1'b0;
         emit_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         cnt_ff    <= cnt_in;
         seq_ff    <= seq_in;
         closed_ff <= closed_in;
         rv_ff     <= rv_in;
         emit_ff   <= emit_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_cmd_ff   <= r_cmd_in;
      r_owner_ff <= r_owner_in;
      r_kind_ff  <= r_kind_in;
      r_dl_ff    <= r_dl_in;
      r_cseq_ff  <= r_cseq_in;
      r_now_ff   <= r_now_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      fidx_ff    <= fidx_in;
      found_ff   <= found_in;
      smatch_ff  <= smatch_in;
      dst_ff     <= dst_in;
      end_ff     <= end_in;
      dirdec_ff  <= dirdec_in;
      ej_ff      <= ej_in;
      aseq_ff    <= aseq_in;
      rst_ff     <= rst_in;
      rfired_ff  <= rfired_in;
      rown_ff    <= rown_in;
      rseq_ff    <= rseq_in;
      rknd_ff    <= rknd_in;
      rdl_ff     <= rdl_in;
      rcnt_ff    <= rcnt_in;
      rlast_ff   <= rlast_in;
   end

   // ------------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------------
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = {rfired_ff, rst_ff};
   assign rsp_tdata  = {7'd0, closed_ff, rcnt_ff, rdl_ff, rknd_ff, rseq_ff, rown_ff};

endmodule
